// ===== rtl/mwo_pkg.sv =====
`default_nettype none

package mwo_pkg;

	localparam int NUM_WAVES_DEF  = 16;
	localparam int TABLE_SIZE_DEF = 256;
	localparam int NUM_BANKS_DEF  = 2;

	localparam int PHASE_W  = 32;
	localparam int SAMPLE_W = 16;
	localparam int AXIS_W   = 12;
	localparam int FRAC_W   = 12;
	localparam int OUT_W    = 12;
	localparam int T_W      = FRAC_W + 1;
	localparam int DIFF_W   = SAMPLE_W + 1;
	localparam int PROD_W   = DIFF_W + T_W + 1;

	localparam logic [AXIS_W-1:0] AXIS_MAX = 12'hFFF;
	localparam logic [T_W-1:0]    FRAC_ONE = 13'h1000;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_RENDER = 1'b1;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;
	localparam step_t STEP_IDLE  = 4'd0;
	localparam step_t STEP_FIRST = 4'd1;
	localparam step_t STEP_LAST  = 4'd12;

	typedef enum logic [1:0] {CAP_NONE, CAP_A, CAP_B} cap_t;
	typedef enum logic [1:0] {LERP_NONE, LERP_SA, LERP_SB, LERP_MORPH} lerp_t;
	typedef enum logic [1:0] {OUT_NONE, OUT_HOLD1, OUT_PUSH} outop_t;
	typedef enum logic [1:0] {JMP_NEXT, JMP_WAIT_IN, JMP_WAIT_OUT} jump_t;

	typedef struct packed {
		logic   rd_en;
		logic   rd_voice;
		logic   rd_wave;
		logic   rd_nxt;
		cap_t   cap;
		lerp_t  lerp;
		logic   mvoice;
		outop_t outop;
		jump_t  jump;
	} ctrl_t;

	typedef struct packed {
		ctrl_t uc;
		logic  wr_en;
		logic  start;
		logic  push;
	} seq_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

	// Program ROM. A read issued in one step lands in the read register at the end of
	// that step and is captured into an operand register in the next step.
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t w;
		w = '0;
		w.jump = JMP_NEXT;
		case (step)
			STEP_IDLE: begin
				w.jump = JMP_WAIT_IN;
			end
			4'd1: begin
				w.rd_en = 1'b1;
			end
			4'd2: begin
				w.rd_en = 1'b1; w.rd_nxt = 1'b1; w.cap = CAP_A;
			end
			4'd3: begin
				w.rd_en = 1'b1; w.rd_wave = 1'b1; w.cap = CAP_B;
			end
			4'd4: begin
				w.rd_en = 1'b1; w.rd_wave = 1'b1; w.rd_nxt = 1'b1;
				w.cap = CAP_A; w.lerp = LERP_SA;
			end
			4'd5: begin
				w.rd_en = 1'b1; w.rd_voice = 1'b1; w.cap = CAP_B;
			end
			4'd6: begin
				w.rd_en = 1'b1; w.rd_voice = 1'b1; w.rd_nxt = 1'b1;
				w.cap = CAP_A; w.lerp = LERP_SB;
			end
			4'd7: begin
				w.rd_en = 1'b1; w.rd_voice = 1'b1; w.rd_wave = 1'b1;
				w.cap = CAP_B; w.lerp = LERP_MORPH;
			end
			4'd8: begin
				w.rd_en = 1'b1; w.rd_voice = 1'b1; w.rd_wave = 1'b1; w.rd_nxt = 1'b1;
				w.cap = CAP_A; w.lerp = LERP_SA; w.outop = OUT_HOLD1;
			end
			4'd9: begin
				w.cap = CAP_B;
			end
			4'd10: begin
				w.lerp = LERP_SB;
			end
			4'd11: begin
				w.lerp = LERP_MORPH; w.mvoice = 1'b1;
			end
			STEP_LAST: begin
				w.outop = OUT_PUSH; w.jump = JMP_WAIT_OUT;
			end
			default: begin
				w.jump = JMP_WAIT_OUT;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/mwo_if.sv =====
`default_nettype none

interface mwo_cmd_if;
	logic                valid;
	logic                ready;
	logic                mode;
	logic                bank;
	logic [3:0]          wave_number;
	logic [7:0]          entry_number;
	logic signed [15:0]  entry_value;
	logic [31:0]         phase_step;
	logic [11:0]         morph_x;
	logic [11:0]         morph_y;

	modport source (output valid, mode, bank, wave_number, entry_number, entry_value,
		phase_step, morph_x, morph_y, input ready);
	modport sink (input valid, mode, bank, wave_number, entry_number, entry_value,
		phase_step, morph_x, morph_y, output ready);
endinterface

interface mwo_smp_if;
	logic                valid;
	logic                ready;
	logic signed [11:0]  sample_out1;
	logic signed [11:0]  sample_out2;

	modport source (output valid, sample_out1, sample_out2, input ready);
	modport sink (input valid, sample_out1, sample_out2, output ready);
endinterface

`default_nettype wire

// ===== rtl/mwo_sequencer.sv =====
`default_nettype none

module mwo_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic              cmd_mode,
	input  mwo_pkg::dp_stat_t stat,
	output logic              cmd_ready,
	output mwo_pkg::seq_cmd_t seq
);
	import mwo_pkg::*;

	step_t pc_q;
	step_t pc_d;
	ctrl_t uc;
	logic  accept;

	always_comb uc = ucode(pc_q);

	always_comb begin
		cmd_ready = (uc.jump == JMP_WAIT_IN);
		accept    = cmd_valid && cmd_ready;
		seq.uc    = uc;
		seq.wr_en = accept && (cmd_mode == MODE_WRITE);
		seq.start = accept && (cmd_mode == MODE_RENDER);
		seq.push  = (uc.outop == OUT_PUSH) && stat.out_free;
	end

	always_comb begin
		unique case (uc.jump)
			JMP_NEXT:     pc_d = pc_q + 1'b1;
			JMP_WAIT_IN:  pc_d = seq.start ? STEP_FIRST : pc_q;
			JMP_WAIT_OUT: pc_d = stat.out_free ? STEP_IDLE : pc_q;
			default:      pc_d = STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	a_start_enters_program: assert property (@(posedge clk) disable iff (!arst_n)
		seq.start |=> pc_q == STEP_FIRST)
		else $error("render transaction did not start the program");

	a_pc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= STEP_LAST)
		else $error("step counter left the program");

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q != STEP_IDLE) |-> !cmd_ready)
		else $error("input ready while a render is in progress");

endmodule

`default_nettype wire

// ===== rtl/mwo_datapath.sv =====
`default_nettype none

module mwo_datapath #(
	parameter int NUM_WAVES  = mwo_pkg::NUM_WAVES_DEF,
	parameter int TABLE_SIZE = mwo_pkg::TABLE_SIZE_DEF,
	parameter int NUM_BANKS  = mwo_pkg::NUM_BANKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mwo_pkg::seq_cmd_t  cmd,
	output mwo_pkg::dp_stat_t  stat,
	input  logic               bank,
	input  logic [3:0]         wave_number,
	input  logic [7:0]         entry_number,
	input  logic signed [15:0] entry_value,
	input  logic [31:0]        phase_step,
	input  logic [11:0]        morph_x,
	input  logic [11:0]        morph_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [11:0] sample_out1,
	output logic signed [11:0] sample_out2
);
	import mwo_pkg::*;

	localparam int WIDX_W = $clog2(NUM_WAVES);
	localparam int POS_W  = $clog2(TABLE_SIZE);
	localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
	localparam int DEPTH  = NUM_BANKS * NUM_WAVES * TABLE_SIZE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int ISHIFT = PHASE_W - POS_W;
	localparam int FSHIFT = ISHIFT - FRAC_W;
	localparam int WPOS_W = AXIS_W + WIDX_W;
	localparam int SPLIT_W = WIDX_W + T_W;

	function automatic logic [ADDR_W-1:0] addr_of(input logic [BANK_W-1:0] b,
		input logic [WIDX_W-1:0] w, input logic [POS_W-1:0] p);
		return ADDR_W'((ADDR_W'(b) * ADDR_W'(NUM_WAVES) + ADDR_W'(w)) * ADDR_W'(TABLE_SIZE)
			+ ADDR_W'(p));
	endfunction

	// Base wave index and Q12 fraction toward the next wave for one morph axis.
	function automatic logic [SPLIT_W-1:0] morph_split(input logic [AXIS_W-1:0] axis);
		logic [WPOS_W-1:0] wpos;
		logic [WIDX_W-1:0] widx;
		logic [T_W-1:0]    wfrac;
		wpos = WPOS_W'(axis) * WPOS_W'(NUM_WAVES - 1);
		widx = wpos[WPOS_W-1:FRAC_W];
		if (32'(widx) > NUM_WAVES - 2) begin
			widx = WIDX_W'(NUM_WAVES - 2);
		end
		wfrac = {1'b0, wpos[FRAC_W-1:0]};
		if (axis == AXIS_MAX) begin
			wfrac = FRAC_ONE;
		end
		return {widx, wfrac};
	endfunction

	// a + floor((b - a) * t / 4096); the result stays between a and b for t up to one.
	function automatic logic signed [SAMPLE_W-1:0] lerp(input logic signed [SAMPLE_W-1:0] a,
		input logic signed [SAMPLE_W-1:0] b, input logic [T_W-1:0] t);
		logic signed [DIFF_W-1:0] diff;
		logic signed [PROD_W-1:0] prod;
		logic signed [DIFF_W-1:0] sum;
		diff = DIFF_W'(b) - DIFF_W'(a);
		prod = PROD_W'(diff) * PROD_W'($signed({1'b0, t}));
		sum  = DIFF_W'(a) + $signed(prod[FRAC_W +: DIFF_W]);
		return sum[SAMPLE_W-1:0];
	endfunction

	logic [SAMPLE_W-1:0]        mem [DEPTH];
	logic [SAMPLE_W-1:0]        rdata_q;
	logic [PHASE_W-1:0]         phase_q;
	logic [BANK_W-1:0]          bank_q;
	logic [WIDX_W-1:0]          widx0_q, widx1_q;
	logic [T_W-1:0]             wfrac0_q, wfrac1_q;
	logic signed [SAMPLE_W-1:0] ra_q, rb_q, sa_q, sb_q, m_q;
	logic signed [OUT_W-1:0]    o1_q, smp1_q, smp2_q;
	logic                       out_valid_q;

	logic [BANK_W-1:0]          bank_eff;
	logic                       wr_ok;
	logic [ADDR_W-1:0]          waddr, raddr;
	logic [SPLIT_W-1:0]         split_x, split_y;
	logic [POS_W-1:0]           raw, pos, nxt, rpos;
	logic [WIDX_W-1:0]          rwave;
	logic [T_W-1:0]             sfrac, lt;
	logic signed [SAMPLE_W-1:0] la, lb, lres;

	always_comb begin
		bank_eff = (NUM_BANKS > 1) ? BANK_W'(bank) : '0;
		wr_ok    = (32'(wave_number) < NUM_WAVES) && (32'(entry_number) < TABLE_SIZE);
		waddr    = addr_of(bank_eff, WIDX_W'(wave_number), POS_W'(entry_number));
		split_x  = morph_split(morph_x);
		split_y  = morph_split(morph_y);
	end

	// Sample position wraps at the wave length, which need not be a power of two.
	always_comb begin
		raw   = phase_q[PHASE_W-1 -: POS_W];
		pos   = (32'(raw) >= TABLE_SIZE) ? raw - POS_W'(TABLE_SIZE) : raw;
		nxt   = (32'(pos) + 1 == TABLE_SIZE) ? '0 : pos + 1'b1;
		sfrac = {1'b0, phase_q[FSHIFT +: FRAC_W]};
		rwave = (cmd.uc.rd_voice ? widx1_q : widx0_q) + WIDX_W'(cmd.uc.rd_wave);
		rpos  = cmd.uc.rd_nxt ? nxt : pos;
		raddr = addr_of(bank_q, rwave, rpos);
	end

	always_comb begin
		if (cmd.uc.lerp == LERP_MORPH) begin
			la = sa_q;
			lb = sb_q;
			lt = cmd.uc.mvoice ? wfrac1_q : wfrac0_q;
		end else begin
			la = ra_q;
			lb = rb_q;
			lt = sfrac;
		end
		lres = lerp(la, lb, lt);
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_ok) begin
			mem[waddr] <= entry_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.uc.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (cmd.start) begin
			phase_q <= phase_q + phase_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			bank_q   <= bank_eff;
			widx0_q  <= split_x[SPLIT_W-1:T_W];
			wfrac0_q <= split_x[T_W-1:0];
			widx1_q  <= split_y[SPLIT_W-1:T_W];
			wfrac1_q <= split_y[T_W-1:0];
		end
		case (cmd.uc.cap)
			CAP_A:   ra_q <= rdata_q;
			CAP_B:   rb_q <= rdata_q;
			default: ;
		endcase
		case (cmd.uc.lerp)
			LERP_SA:    sa_q <= lres;
			LERP_SB:    sb_q <= lres;
			LERP_MORPH: m_q  <= lres;
			default:    ;
		endcase
		// The floor shift by four of a 16-bit value already spans the 12-bit output range.
		if (cmd.uc.outop == OUT_HOLD1) begin
			o1_q <= m_q[SAMPLE_W-1 -: OUT_W];
		end
		if (cmd.push) begin
			smp1_q <= o1_q;
			smp2_q <= m_q[SAMPLE_W-1 -: OUT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign sample_out1   = smp1_q;
	assign sample_out2   = smp2_q;

	a_push_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || out_ready))
		else $error("result pushed over an untaken result");

	a_push_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> out_valid_q)
		else $error("pushed result not presented");

	a_write_or_render: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_en && cmd.start))
		else $error("write and render decoded from one transaction");

endmodule

`default_nettype wire

// ===== rtl/morphing_wavetable_oscillator.sv =====
// Two-voice morphing wavetable oscillator on one shared wave memory.
// cmd channel: each transaction is either a table write (mode 0) that stores
// entry_value at bank/wave_number/entry_number, or a render (mode 1) that adds
// phase_step to the phase and produces one pair of samples, one voice morphed
// by morph_x and the other by morph_y, both reading the bank given with it.
// smp channel: one transaction of sample_out1/sample_out2 per render.
// A write gives no result. Input ready returns only when the program has ended
// and the result has gone to the output register, so a render is not taken
// while another is in progress: the program reads eight samples through the
// single read port of the wave memory and runs six interpolations on one
// shared multiply-add unit, and pushes the result on its last step.
// The result sits in an output register, so a stalled receiver does not stop
// the next render; that render waits on its last step until the register is
// free, and no result is lost or repeated.
// Reset clears the phase, the step counter and the output valid flag. The wave
// memory is not cleared; render only from entries that have been written.
`default_nettype none

module morphing_wavetable_oscillator #(
	parameter int NUM_WAVES  = mwo_pkg::NUM_WAVES_DEF,
	parameter int TABLE_SIZE = mwo_pkg::TABLE_SIZE_DEF,
	parameter int NUM_BANKS  = mwo_pkg::NUM_BANKS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mwo_cmd_if.sink   cmd,
	mwo_smp_if.source smp
);
	import mwo_pkg::*;

	seq_cmd_t seq;
	dp_stat_t stat;

	mwo_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_mode  (cmd.mode),
		.stat      (stat),
		.cmd_ready (cmd.ready),
		.seq       (seq)
	);

	mwo_datapath #(
		.NUM_WAVES  (NUM_WAVES),
		.TABLE_SIZE (TABLE_SIZE),
		.NUM_BANKS  (NUM_BANKS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (seq),
		.stat         (stat),
		.bank         (cmd.bank),
		.wave_number  (cmd.wave_number),
		.entry_number (cmd.entry_number),
		.entry_value  (cmd.entry_value),
		.phase_step   (cmd.phase_step),
		.morph_x      (cmd.morph_x),
		.morph_y      (cmd.morph_y),
		.out_valid    (smp.valid),
		.out_ready    (smp.ready),
		.sample_out1  (smp.sample_out1),
		.sample_out2  (smp.sample_out2)
	);

endmodule

`default_nettype wire
